@@ rtl/lbm_pkg.sv @@
// Shared constants, types and the arctangent table for the lidar box mask unit.
package lbm_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int NUM_STEPS    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int STEP_W       = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

   localparam int VEC_W = 35;
   localparam int ANG_W = 24;

   localparam logic [15:0] NO_RETURN = 16'hFFFF;
   localparam logic [15:0] GAIN_Q16  = 16'd39797;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_STEP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_X_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_X_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Y_LOW   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Y_HIGH  = 3'd5;

   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic signed [ANG_W-1:0] ang_type;

   // atan(2^-i) in units of 2^-24 turn
   function automatic ang_type atan_turn(input logic [4:0] idx);
      ang_type val;
      case (idx)
         5'd0:    val = 24'sd2097152;
         5'd1:    val = 24'sd1238021;
         5'd2:    val = 24'sd654136;
         5'd3:    val = 24'sd332050;
         5'd4:    val = 24'sd166669;
         5'd5:    val = 24'sd83416;
         5'd6:    val = 24'sd41718;
         5'd7:    val = 24'sd20860;
         5'd8:    val = 24'sd10430;
         5'd9:    val = 24'sd5215;
         5'd10:   val = 24'sd2608;
         5'd11:   val = 24'sd1304;
         5'd12:   val = 24'sd652;
         5'd13:   val = 24'sd326;
         5'd14:   val = 24'sd163;
         5'd15:   val = 24'sd81;
         5'd16:   val = 24'sd41;
         5'd17:   val = 24'sd20;
         5'd18:   val = 24'sd10;
         5'd19:   val = 24'sd5;
         5'd20:   val = 24'sd3;
         5'd21:   val = 24'sd1;
         5'd22:   val = 24'sd1;
         default: val = 24'sd0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/lbm_req_if.sv @@
// Sample channel: one range sample with its scan start flag per transaction.
interface lbm_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] range_in;
   logic        scan_start;

   modport source (output valid, output range_in, output scan_start, input ready);
   modport sink   (input valid, input range_in, input scan_start, output ready);
endinterface

@@ rtl/lbm_rsp_if.sv @@
// Result channel: filtered range and masked flag per transaction.
interface lbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] range_out;
   logic        masked;

   modport source (output valid, output range_out, output masked, input ready);
   modport sink   (input valid, input range_out, input masked, output ready);
endinterface

@@ rtl/lidar_box_mask_unit.sv @@
// Lidar box mask unit: rotates each range sample to x/y by CORDIC and masks points in a box.
//
// Each sample is worked in order: the transaction is taken and the range scaled by
// the CORDIC gain, then the NUM_STEPS CORDIC steps run one by one through a single
// shared add/subtract-and-shift datapath, then the quadrant fold and the inclusive
// box compare, held while the output register is full. A new sample is
// taken only once the previous one has left the datapath; the finished result
// waits in an output register, so the next sample can start while it is held.
// Samples at the no-return range of 65535 pass through and are never masked.
// Configuration writes land at once and must only be made while the unit is idle.
module lidar_box_mask_unit
   import lbm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   lbm_req_if.sink              req_ch,
   lbm_rsp_if.source            rsp_ch,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_write_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ITER = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [15:0]        angle_start_ff, angle_step_ff;
   logic signed [15:0] box_x_low_ff, box_x_high_ff, box_y_low_ff, box_y_high_ff;
   logic [15:0]        beam_angle_ff, beam_angle_in;

   vec_type     x_ff, x_in, y_ff, y_in;
   ang_type     z_ff, z_in;
   logic [1:0]  quad_ff, quad_in;
   logic [15:0] range_ff, range_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_range_ff, rsp_range_in;
   logic        rsp_masked_ff, rsp_masked_in;

   logic        accept;
   logic        load_rsp;
   logic [15:0] angle;
   logic [15:0] angle_round;
   logic [15:0] residual;
   logic [31:0] scaled;
   vec_type     dx, dy;
   ang_type     atan_val;
   vec_type     px, py;
   vec_type     bx_lo, bx_hi, by_lo, by_hi;
   logic        hit;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // Sample angle, quadrant and residual in [-1/8, 1/8) turn
   assign angle       = req_ch.scan_start ? angle_start_ff : beam_angle_ff;
   assign angle_round = angle + 16'h2000;
   assign residual    = angle - {angle_round[15:14], 14'h0000};
   assign scaled      = req_ch.range_in * GAIN_Q16;

   // Shared CORDIC datapath
   assign dx       = y_ff >>> step_ff;
   assign dy       = x_ff >>> step_ff;
   assign atan_val = atan_turn(5'(step_ff));

   // Fold back the quadrant
   always_comb begin
      unique case (quad_ff)
         2'd0: begin
            px = x_ff;
            py = y_ff;
         end
         2'd1: begin
            px = -y_ff;
            py = x_ff;
         end
         2'd2: begin
            px = -x_ff;
            py = -y_ff;
         end
         default: begin
            px = y_ff;
            py = -x_ff;
         end
      endcase
   end

   assign bx_lo = {{3{box_x_low_ff[15]}}, box_x_low_ff, 16'h0000};
   assign bx_hi = {{3{box_x_high_ff[15]}}, box_x_high_ff, 16'h0000};
   assign by_lo = {{3{box_y_low_ff[15]}}, box_y_low_ff, 16'h0000};
   assign by_hi = {{3{box_y_high_ff[15]}}, box_y_high_ff, 16'h0000};

   assign hit = (range_ff != NO_RETURN) && (bx_lo <= px) && (px <= bx_hi)
                && (by_lo <= py) && (py <= by_hi);

   assign load_rsp = (state_ff == ST_CMP) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      beam_angle_in = beam_angle_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      quad_in       = quad_ff;
      range_in      = range_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               beam_angle_in = angle + angle_step_ff;
               x_in          = {3'b000, scaled};
               y_in          = '0;
               z_in          = {residual, 8'h00};
               quad_in       = angle_round[15:14];
               range_in      = req_ch.range_in;
               step_in       = '0;
               state_in      = ST_ITER;
            end
         end
         ST_ITER: begin
            if (!z_ff[ANG_W-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_val;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_val;
            end
            if (step_ff == STEP_W'(NUM_STEPS - 1)) begin
               state_in = ST_CMP;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_CMP: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load a finished result, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_range_in  = rsp_range_ff;
      rsp_masked_in = rsp_masked_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_range_in  = hit ? NO_RETURN : range_ff;
         rsp_masked_in = hit;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         beam_angle_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         angle_start_ff <= '0;
         angle_step_ff  <= '0;
         box_x_low_ff   <= '0;
         box_x_high_ff  <= '0;
         box_y_low_ff   <= '0;
         box_y_high_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         beam_angle_ff <= beam_angle_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_ANGLE_START: angle_start_ff <= csr_write_data;
               CSR_ANGLE_STEP:  angle_step_ff  <= csr_write_data;
               CSR_BOX_X_LOW:   box_x_low_ff   <= csr_write_data;
               CSR_BOX_X_HIGH:  box_x_high_ff  <= csr_write_data;
               CSR_BOX_Y_LOW:   box_y_low_ff   <= csr_write_data;
               CSR_BOX_Y_HIGH:  box_y_high_ff  <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      quad_ff       <= quad_in;
      range_ff      <= range_in;
      rsp_range_ff  <= rsp_range_in;
      rsp_masked_ff <= rsp_masked_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.range_out = rsp_range_ff;
   assign rsp_ch.masked    = rsp_masked_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("sample taken while previous one still in datapath");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER) |-> (step_ff <= STEP_W'(NUM_STEPS - 1)))
      else $error("CORDIC step counter out of range");

   a_masked_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.masked) |-> (rsp_ch.range_out == NO_RETURN))
      else $error("masked result without no-return code");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CMP) && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == ST_CMP))
      else $error("result lost while output register full");

   a_iter_to_cmp: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ITER) && (step_ff == STEP_W'(NUM_STEPS - 1))) |=> (state_ff == ST_CMP))
      else $error("sequencer skipped the compare cycle");
`endif

endmodule

@@ sim/tb_lidar_box_mask_unit.sv @@
// Testbench for lidar_box_mask_unit: directed and random scans checked against a CORDIC predictor.
module tb_lidar_box_mask_unit
   import lbm_pkg::*;
();

   localparam int  RANDOM_GOAL   = 1690;
   localparam int  PRESSURE_ITEMS = 40;
   localparam int  IDLE_TAIL     = 24;
   localparam int  CYCLE_LIMIT   = 1000000;
   localparam int  MAX_REPORTS   = 10;

   // Indexes past the last register; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE_B = 3'd7;

   typedef struct {
      logic [15:0] range_out;
      logic        masked;
   } mask_result_type;

   typedef enum {BOX_AROUND_ORIGIN, BOX_OFFSET, BOX_ANY, BOX_EMPTY, BOX_FULL}
      box_mode_type;
   typedef enum {RX_STEADY, RX_COIN, RX_SPARSE_STALL, RX_MOSTLY_STALL} rx_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_write_data;

   lbm_req_if req_ch ();
   lbm_rsp_if rsp_ch ();

   lidar_box_mask_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Arctangent of 2^-i in units of 2^-24 turn
   longint atan_turn24 [24] = '{
      2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
      10430, 5215, 2608, 1304, 652, 326, 163, 81,
      41, 20, 10, 5, 3, 1, 1, 0
   };

   // Shadow of the unit's configuration and running angle
   logic [15:0] cfg_angle_start;
   logic [15:0] cfg_angle_step;
   shortint     cfg_x_low;
   shortint     cfg_x_high;
   shortint     cfg_y_low;
   shortint     cfg_y_high;
   logic [15:0] next_beam_angle;

   mask_result_type pending_results [$];
   int              mismatch_count;
   int              cycle_count;
   int              burst_left;

   bit          hold_off_request;
   int          hold_left;
   rx_mode_type rx_mode;
   int          rx_mode_left;
   int          rx_tick;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic bit point_in_box(input logic [15:0] rng, input logic [15:0] ang);
      longint a, q, x, y, z, dx, dy, px, py;
      a = longint'(ang);
      q = ((a + 8192) >> 14) & 3;
      z = a - q * 16384;
      if (q == 0 && a >= 57344)
         z = a - 65536;
      z = z * 256;
      x = longint'(rng) * longint'(GAIN_Q16);
      y = 0;
      for (int i = 0; i < NUM_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_turn24[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_turn24[i];
         end
      end
      case (q)
         0: begin
            px = x;
            py = y;
         end
         1: begin
            px = -y;
            py = x;
         end
         2: begin
            px = -x;
            py = -y;
         end
         default: begin
            px = y;
            py = -x;
         end
      endcase
      return (longint'(cfg_x_low) * 65536 <= px) && (px <= longint'(cfg_x_high) * 65536) &&
             (longint'(cfg_y_low) * 65536 <= py) && (py <= longint'(cfg_y_high) * 65536);
   endfunction

   // Advance the running angle and work out the result of one accepted sample
   function automatic mask_result_type predict_sample(input logic [15:0] rng,
                                                      input logic start);
      mask_result_type res;
      logic [15:0]     ang;
      bit              hit;
      ang = start ? cfg_angle_start : next_beam_angle;
      next_beam_angle = ang + cfg_angle_step;
      hit = (rng != NO_RETURN) && point_in_box(rng, ang);
      res.range_out = hit ? NO_RETURN : rng;
      res.masked    = hit;
      return res;
   endfunction

   function automatic void note_mismatch(input string what, input mask_result_type want,
                                         input logic [15:0] got_range, input logic got_masked);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected range_out=%0d masked=%0b, got range_out=%0d masked=%0b",
                  $time, what, want.range_out, want.masked, got_range, got_masked);
   endfunction

   always @(posedge clock) begin : check_results
      mask_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            want.range_out = 16'h0;
            want.masked    = 1'b0;
            note_mismatch("result with nothing outstanding", want, rsp_ch.range_out,
                          rsp_ch.masked);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.range_out !== want.range_out || rsp_ch.masked !== want.masked)
               note_mismatch("result mismatch", want, rsp_ch.range_out, rsp_ch.masked);
         end
      end
   end

   // Result side: long hold-off on request, otherwise a changing stall pattern
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         rsp_ch.ready <= 1'b0;
         hold_left <= $urandom_range(300, 500);
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 300);
            rx_tick      = 0;
         end else begin
            rx_mode_left = rx_mode_left - 1;
            rx_tick      = rx_tick + 1;
         end
         case (rx_mode)
            RX_STEADY:       rsp_ch.ready <= 1'b1;
            RX_COIN:         rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE_STALL: rsp_ch.ready <= (rx_tick % 7) != 0;
            default:         rsp_ch.ready <= (rx_tick % 9) < 2;
         endcase
      end
   end

   // Call at a falling edge; return at a falling edge
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_ANGLE_START: cfg_angle_start = data;
         CSR_ANGLE_STEP:  cfg_angle_step  = data;
         CSR_BOX_X_LOW:   cfg_x_low       = shortint'(data);
         CSR_BOX_X_HIGH:  cfg_x_high      = shortint'(data);
         CSR_BOX_Y_LOW:   cfg_y_low       = shortint'(data);
         CSR_BOX_Y_HIGH:  cfg_y_high      = shortint'(data);
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_box(input int x_lo, input int x_hi, input int y_lo, input int y_hi);
      csr_write(CSR_BOX_X_LOW,  16'(x_lo));
      csr_write(CSR_BOX_X_HIGH, 16'(x_hi));
      csr_write(CSR_BOX_Y_LOW,  16'(y_lo));
      csr_write(CSR_BOX_Y_HIGH, 16'(y_hi));
   endtask

   task automatic write_angles(input logic [15:0] start_ang, input logic [15:0] step_ang);
      csr_write(CSR_ANGLE_START, start_ang);
      csr_write(CSR_ANGLE_STEP,  step_ang);
   endtask

   // Offer one sample in bursts with random gaps; keep valid high inside a burst
   task automatic send_sample(input logic [15:0] rng, input logic start);
      int              gap;
      mask_result_type expect_res;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_ch.valid      <= 1'b1;
      req_ch.range_in   <= rng;
      req_ch.scan_start <= start;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      expect_res = predict_sample(rng, start);
      pending_results.insert(pending_results.size(), expect_res);
      burst_left--;
      @(negedge clock);
   endtask

   // Drop valid, wait for every outstanding result, then let the datapath settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do
         @(negedge clock);
      while (pending_results.size() != 0);
      repeat (IDLE_TAIL) @(negedge clock);
   endtask

   function automatic int pick_bound();
      case ($urandom_range(0, 5))
         0:       return -32768;
         1:       return 32767;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Reset values: box collapsed to the origin point, running angle zero before any scan start
   task automatic test_reset_state();
      send_sample(16'd0, 1'b0);
      send_sample(NO_RETURN, 1'b0);
      send_sample(16'd1, 1'b1);
      send_sample(16'h8000, 1'b0);
   endtask

   // Quadrant seams of the angle fold, plus wrap of the running angle
   task automatic test_quadrant_edges();
      wait_idle();
      write_box(-2000, 2000, -2000, 2000);
      write_angles(16'h1FFF, 16'h4000);
      send_sample(16'd1500, 1'b1);
      send_sample(16'd1999, 1'b0);
      send_sample(16'd2001, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(NO_RETURN, 1'b0);
      wait_idle();
      write_angles(16'h2000, 16'h4000);
      send_sample(16'd1414, 1'b1);
      send_sample(16'd2828, 1'b0);
      send_sample(16'd1000, 1'b0);
      send_sample(16'd1999, 1'b0);
      wait_idle();
      write_angles(16'hFFFF, 16'hFFFF);
      send_sample(16'd65534, 1'b1);
      send_sample(16'd1, 1'b0);
   endtask

   task automatic test_box_extremes();
      wait_idle();
      // empty in x: even the origin stays
      write_box(10, -10, -32768, 32767);
      send_sample(16'd0, 1'b1);
      wait_idle();
      write_box(-32768, 32767, -32768, 32767);
      send_sample(16'd32767, 1'b1);
      send_sample(16'd65534, 1'b0);
      wait_idle();
      write_box(-32768, 32767, 5, -5);
      send_sample(16'd0, 1'b1);
   endtask

   task automatic test_spare_index();
      wait_idle();
      write_box(-100, 100, -100, 100);
      csr_write(CSR_IDX_SPARE_A, 16'hFFFF);
      csr_write(CSR_IDX_SPARE_B, 16'h8000);
      send_sample(16'd50, 1'b1);
      send_sample(16'd150, 1'b0);
   endtask

   // Hold the result side off while samples keep coming, so the input stalls
   task automatic test_result_backpressure();
      wait_idle();
      write_angles(16'd0, 16'd91);
      write_box(-1500, 1500, -1500, 1500);
      hold_off_request = 1'b1;
      for (int n = 0; n < PRESSURE_ITEMS; n++)
         send_sample(16'($urandom_range(0, 3000)), n == 0);
   endtask

   task automatic test_random_scans(input int item_goal);
      int           sent, phase_len, scan_len, pos, range_cap;
      int           x_lo, x_hi, y_lo, y_hi, hw, hh, cx, cy, tmp;
      logic [15:0]  start_ang, step_ang, rng;
      logic         start;
      box_mode_type box_mode;
      sent = 0;
      while (sent < item_goal) begin
         wait_idle();
         case ($urandom_range(0, 5))
            0:       start_ang = 16'h0000;
            1:       start_ang = 16'hFFFF;
            default: start_ang = 16'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 5))
            0:       step_ang = 16'h0000;
            1:       step_ang = 16'hFFFF;
            2, 3:    step_ang = 16'($urandom_range(1, 512));
            default: step_ang = 16'($urandom_range(0, 65535));
         endcase
         box_mode = box_mode_type'($urandom_range(0, 4));
         case (box_mode)
            BOX_AROUND_ORIGIN: begin
               x_lo = -int'($urandom_range(0, 4000));
               x_hi = $urandom_range(0, 4000);
               y_lo = -int'($urandom_range(0, 4000));
               y_hi = $urandom_range(0, 4000);
               range_cap = 6000;
            end
            BOX_OFFSET: begin
               cx = int'($urandom_range(0, 12000)) - 6000;
               cy = int'($urandom_range(0, 12000)) - 6000;
               hw = $urandom_range(50, 3000);
               hh = $urandom_range(50, 3000);
               x_lo = cx - hw;
               x_hi = cx + hw;
               y_lo = cy - hh;
               y_hi = cy + hh;
               range_cap = 12000;
            end
            BOX_ANY: begin
               x_lo = pick_bound();
               x_hi = pick_bound();
               y_lo = pick_bound();
               y_hi = pick_bound();
               range_cap = 65535;
            end
            BOX_EMPTY: begin
               x_lo = $urandom_range(0, 32767);
               x_hi = x_lo - 1 - int'($urandom_range(0, 32767));
               y_lo = -int'($urandom_range(0, 3000));
               y_hi = $urandom_range(0, 3000);
               // swap axes half the time so y is the empty one
               if ($urandom_range(0, 1)) begin
                  tmp = x_lo; x_lo = y_lo; y_lo = tmp;
                  tmp = x_hi; x_hi = y_hi; y_hi = tmp;
               end
               range_cap = 4000;
            end
            default: begin
               x_lo = -32768;
               x_hi = 32767;
               y_lo = -32768;
               y_hi = 32767;
               range_cap = 65535;
            end
         endcase
         write_angles(start_ang, step_ang);
         write_box(x_lo, x_hi, y_lo, y_hi);
         phase_len = $urandom_range(60, 140);
         pos = 0;
         scan_len = 1;
         for (int n = 0; n < phase_len; n++) begin
            if (pos == 0)
               scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400)
                                                       : $urandom_range(1, 60);
            // stray scan start now and then
            start = (pos == 0) || ($urandom_range(0, 49) == 0);
            case ($urandom_range(0, 19))
               0:       rng = 16'd0;
               1:       rng = NO_RETURN;
               2, 3:    rng = 16'($urandom_range(0, 65535));
               default: rng = 16'($urandom_range(0, range_cap));
            endcase
            send_sample(rng, start);
            pos = (pos + 1 == scan_len) ? 0 : pos + 1;
         end
         sent += phase_len;
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.range_in   = 16'h0;
      req_ch.scan_start = 1'b0;
      rsp_ch.ready      = 1'b0;
      csr_write_en      = 1'b0;
      csr_index         = CSR_ANGLE_START;
      csr_write_data    = 16'h0;
      cfg_angle_start   = 16'h0;
      cfg_angle_step    = 16'h0;
      cfg_x_low         = 16'sd0;
      cfg_x_high        = 16'sd0;
      cfg_y_low         = 16'sd0;
      cfg_y_high        = 16'sd0;
      next_beam_angle   = 16'h0;
      mismatch_count    = 0;
      cycle_count       = 0;
      burst_left        = 0;
      hold_off_request  = 1'b0;
      hold_left         = 0;
      rx_mode           = RX_STEADY;
      rx_mode_left      = 0;
      rx_tick           = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_quadrant_edges();
      test_box_extremes();
      test_spare_index();
      test_result_backpressure();
      test_random_scans(RANDOM_GOAL);
      wait_idle();

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
